// ===== hw/rtl/rast_pkg.sv =====
// Package for the range-add / range-sum store.
// Holds the sizes, the item kind codes and the sequencer state type; no dependencies.
package rast_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int POS_W        = 11;
    localparam int WALK_W       = ADDR_W + 2;
    localparam int SUM_W        = 64;
    localparam int VAL_W        = 32;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QRD,
        ST_QACC,
        ST_QMUL,
        ST_QDONE,
        ST_UMUL,
        ST_UPREP,
        ST_URD,
        ST_UWR,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/rast_mul.sv =====
// Registered 64 by 11 bit multiplier, product kept modulo 2^64.
// Depends on rast_pkg for the widths.
module rast_mul
    import rast_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [SUM_W-1:0] op_a,
    input  logic [POS_W-1:0] op_b,
    output logic [SUM_W-1:0] prod
);

    logic [SUM_W+POS_W-1:0] full;
    logic [SUM_W-1:0]       prod_reg;

    assign full = {{POS_W{1'b0}}, op_a} * {{SUM_W{1'b0}}, op_b};
    assign prod = prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= full[SUM_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/range_add_range_sum_tree_core.sv =====
// Range-add / range-sum store kept as two Fenwick trees; uses rast_pkg and rast_mul.
// A query on a non-empty range makes two prefix walks, such an add two update walks, and a
// valid load two prefix and two update walks. One word is taken at a time; the shared memory
// port pair and the one multiplier set the pace. After reset a clearing pass zeroes both
// trees, during which s_ready stays low; configuration writes are taken at all times.
module range_add_range_sum_tree_core
    import rast_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [POS_W-1:0]        cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_kind,
    input  logic [POS_W-1:0]        s_index_low,
    input  logic [POS_W-1:0]        s_index_high,
    input  logic signed [VAL_W-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SUM_W-1:0] m_range_sum
);

    // The element array is represented by two Fenwick trees t1 and t2 so that
    // prefix(i) = i * sum1(i) - sum2(i). A range add of d on [a,b] adds (d, d*(a-1))
    // at a and (-d, -d*b) at b+1. A load reads the current element as a prefix
    // difference and then adds the change on the one-position range.
    logic [SUM_W-1:0] t1_mem [MAX_ELEMENTS];
    logic [SUM_W-1:0] t2_mem [MAX_ELEMENTS];
    logic [SUM_W-1:0] rd1_reg, rd2_reg;

    state_t state_reg, state_next;

    logic [POS_W-1:0]  count_reg;
    kind_t             kind_reg;
    logic [POS_W-1:0]  a_reg, b_reg, qpos_reg;
    logic [WALK_W-1:0] idx_reg;
    logic [SUM_W-1:0]  s1_reg, s2_reg, acc_reg, d_reg, dv1_reg, dv2_reg, v_reg;
    logic              phase_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic              m_valid_reg;
    logic [SUM_W-1:0]  m_data_reg;

    // Shared multiplier operands.
    logic             mul_en;
    logic [SUM_W-1:0] mul_a;
    logic [POS_W-1:0] mul_b;
    logic [SUM_W-1:0] prod;

    rast_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Input decoding: clip the range to the positions in use.
    logic [POS_W-1:0] cnt_eff, in_a, in_b;
    logic             in_nonempty, load_ok, accept;
    logic [SUM_W-1:0] prefix_val;
    logic [WALK_W-1:0] idx_low_bit;
    logic [ADDR_W-1:0] mem_addr;
    logic              walk_end_q, walk_end_u, slot_free;

    assign cnt_eff     = (count_reg > POS_W'(MAX_ELEMENTS)) ? POS_W'(MAX_ELEMENTS) : count_reg;
    assign in_a        = (s_index_low == '0) ? POS_W'(1) : s_index_low;
    assign in_b        = (s_index_high > cnt_eff) ? cnt_eff : s_index_high;
    assign in_nonempty = (in_a <= in_b);
    assign load_ok     = (s_index_low != '0) && (s_index_low <= cnt_eff);
    assign accept      = s_valid && s_ready;

    assign prefix_val  = prod - s2_reg;
    assign idx_low_bit = idx_reg & (~idx_reg + WALK_W'(1));
    assign mem_addr    = ADDR_W'(idx_reg - WALK_W'(1));
    assign walk_end_q  = (idx_reg == '0);
    assign walk_end_u  = (idx_reg == '0) || (idx_reg > WALK_W'(MAX_ELEMENTS));
    assign slot_free   = !m_valid_reg || m_ready;

    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_range_sum = m_data_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == ADDR_W'(MAX_ELEMENTS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_LOAD:  state_next = load_ok ? ST_QRD : ST_IDLE;
                        KIND_ADD:   state_next = in_nonempty ? ST_UMUL : ST_IDLE;
                        KIND_QUERY: state_next = in_nonempty ? ST_QRD : ST_OUT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_QRD:   state_next = walk_end_q ? ST_QMUL : ST_QACC;
            ST_QACC:  state_next = ST_QRD;
            ST_QMUL:  state_next = ST_QDONE;
            ST_QDONE: begin
                if (!phase_reg) state_next = ST_QRD;
                else if (kind_reg == KIND_QUERY) state_next = ST_OUT;
                else state_next = ST_UMUL;
            end
            ST_UMUL:  state_next = ST_UPREP;
            ST_UPREP: state_next = ST_URD;
            ST_URD: begin
                if (walk_end_u) state_next = phase_reg ? ST_IDLE : ST_UMUL;
                else state_next = ST_UWR;
            end
            ST_UWR:   state_next = ST_URD;
            ST_OUT:   state_next = slot_free ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        mul_en  = (state_reg == ST_QMUL) || (state_reg == ST_UMUL);
        mul_a   = (state_reg == ST_QMUL) ? s1_reg : d_reg;
        if (state_reg == ST_QMUL) mul_b = qpos_reg;
        else if (!phase_reg) mul_b = a_reg - POS_W'(1);
        else mul_b = b_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            count_reg   <= POS_W'(MAX_ELEMENTS);
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) count_reg <= cfg_data;
            // A new result word goes out once the slot is free; otherwise a taken word clears it.
            if ((state_reg == ST_OUT) && slot_free) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + ADDR_W'(1);
                ST_IDLE: begin
                    phase_reg <= 1'b0;
                    if (accept) begin
                        kind_reg <= kind_t'(s_kind);
                        v_reg    <= {{(SUM_W-VAL_W){s_value[VAL_W-1]}}, s_value};
                        d_reg    <= {{(SUM_W-VAL_W){s_value[VAL_W-1]}}, s_value};
                        s1_reg   <= '0;
                        s2_reg   <= '0;
                        acc_reg  <= '0;
                        if (s_kind == KIND_LOAD) begin
                            a_reg    <= s_index_low;
                            b_reg    <= s_index_low;
                            qpos_reg <= s_index_low;
                            idx_reg  <= WALK_W'(s_index_low);
                        end else begin
                            a_reg    <= in_a;
                            b_reg    <= in_b;
                            qpos_reg <= in_b;
                            idx_reg  <= WALK_W'(in_b);
                        end
                    end
                end
                ST_QACC: begin
                    s1_reg  <= s1_reg + rd1_reg;
                    s2_reg  <= s2_reg + rd2_reg;
                    idx_reg <= idx_reg - idx_low_bit;
                end
                ST_QDONE: begin
                    s1_reg <= '0;
                    s2_reg <= '0;
                    if (!phase_reg) begin
                        acc_reg   <= prefix_val;
                        phase_reg <= 1'b1;
                        qpos_reg  <= a_reg - POS_W'(1);
                        idx_reg   <= WALK_W'(a_reg - POS_W'(1));
                    end else if (kind_reg == KIND_QUERY) begin
                        acc_reg <= acc_reg - prefix_val;
                    end else begin
                        // The change that brings the loaded element to its new value.
                        d_reg     <= v_reg - (acc_reg - prefix_val);
                        phase_reg <= 1'b0;
                    end
                end
                ST_UPREP: begin
                    dv1_reg <= phase_reg ? -d_reg : d_reg;
                    dv2_reg <= phase_reg ? -prod : prod;
                    idx_reg <= phase_reg ? WALK_W'(b_reg) + WALK_W'(1) : WALK_W'(a_reg);
                end
                ST_URD: begin
                    if (walk_end_u) phase_reg <= 1'b1;
                end
                ST_UWR: idx_reg <= idx_reg + idx_low_bit;
                ST_OUT: begin
                    if (slot_free) m_data_reg <= acc_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // Tree memories: one read or one write per cycle at a shared address.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            t1_mem[clr_reg] <= '0;
            t2_mem[clr_reg] <= '0;
        end else if (state_reg == ST_UWR) begin
            t1_mem[mem_addr] <= rd1_reg + dv1_reg;
            t2_mem[mem_addr] <= rd2_reg + dv2_reg;
        end
        if ((state_reg == ST_QRD) || (state_reg == ST_URD)) begin
            rd1_reg <= t1_mem[mem_addr];
            rd2_reg <= t2_mem[mem_addr];
        end
    end

endmodule

// ===== hw/rtl/rast_checker.sv =====
// Port-level checker for the range-add / range-sum store, bound to the top level.
// Depends on rast_pkg for the kind codes.
module rast_checker
    import rast_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic [1:0]       s_kind,
    input logic             m_valid,
    input logic             m_ready,
    input logic [SUM_W-1:0] m_range_sum
);

    // The clearing pass keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready right after reset");

    // An accepted query always leaves the block busy, with the input closed.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_QUERY) |=> !s_ready)
        else $error("input ready in the cycle after an accepted query word");

    // Loads, adds and unused kinds never give a result word.
    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind != KIND_QUERY) && !m_valid |=> !m_valid)
        else $error("result word without a query");

    // A stalled result word holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_range_sum))
        else $error("stalled result word changed");

endmodule

bind range_add_range_sum_tree_core rast_checker u_rast_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_kind      (s_kind),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_range_sum (m_range_sum)
);

// ===== tb/sv/range_add_range_sum_tree_core_tb.sv =====
// Testbench for the range-add / range-sum store: random and directed load, add and query words.
// Depends on rast_pkg and range_add_range_sum_tree_core; predicts sums from a flat element array.
module range_add_range_sum_tree_core_tb
    import rast_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        kind_t             kind;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        logic [VAL_W-1:0]  value;
    } op_word_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [POS_W-1:0]        cfg_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_kind = KIND_LOAD;
    logic [POS_W-1:0]        s_index_low = '0;
    logic [POS_W-1:0]        s_index_high = '0;
    logic signed [VAL_W-1:0] s_value = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [SUM_W-1:0] m_range_sum;

    // The whole element array as the block should see it. A flat array gives the same
    // wrapped sums as the tree, since every tree operation is linear modulo 2^64.
    logic [SUM_W-1:0] elem_val [1:MAX_ELEMENTS];
    int unsigned      elem_count = MAX_ELEMENTS;
    op_word_t         pending_words[$];
    logic [SUM_W-1:0] expected_sums[$];
    bit               failed = 1'b0;
    bit               quiet = 1'b0;      // no idling on either side in the last part
    int unsigned      accepted_words = 0;
    int unsigned      send_gap = 0;
    int unsigned      recv_gap = 0;
    int unsigned      long_hold = 0;
    bit               long_hold_done = 1'b0;

    range_add_range_sum_tree_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_index_low(s_index_low), .s_index_high(s_index_high), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_range_sum(m_range_sum)
    );

    always #10 aclk = ~aclk;

    // Applies one accepted word to the element array and queues the sum a query produces.
    task automatic apply_word(input op_word_t w);
        int unsigned      cnt;
        int unsigned      a;
        int unsigned      b;
        logic [SUM_W-1:0] delta;
        logic [SUM_W-1:0] acc;
        cnt = (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : elem_count;
        a = 32'(w.lo);
        b = 32'(w.hi);
        delta = {{(SUM_W-VAL_W){w.value[VAL_W-1]}}, w.value};
        acc = '0;
        case (w.kind)
            KIND_LOAD: begin
                if (a >= 1 && a <= cnt) elem_val[a] = delta;
            end
            KIND_ADD: begin
                if (a < 1) a = 1;
                if (b > cnt) b = cnt;
                for (int i = a; i <= b; i++) elem_val[i] += delta;
            end
            KIND_QUERY: begin
                if (a < 1) a = 1;
                if (b > cnt) b = cnt;
                for (int i = a; i <= b; i++) acc += elem_val[i];
                expected_sums.push_back(acc);
            end
            default: ;
        endcase
    endtask

    // Driver: a word is taken off the pending queue only once the previous one was accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_word(op_word_t'{kind_t'(s_kind), s_index_low, s_index_high, s_value});
                accepted_words++;
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    op_word_t w;
                    w = pending_words.pop_front();
                    s_kind       <= w.kind;
                    s_index_low  <= w.lo;
                    s_index_high <= w.hi;
                    s_value      <= w.value;
                    s_valid      <= 1'b1;
                    if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 6);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted sum and stalls the result side at random. Once, the
    // receiver holds off for a long stretch so that the block backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected sum, expected none, actual %0d",
                             $time, m_range_sum);
                    failed = 1'b1;
                end else begin
                    logic [SUM_W-1:0] want;
                    want = expected_sums.pop_front();
                    if (want !== m_range_sum) begin
                        $display("%0t: range_sum expected %0d, actual %0d",
                                 $time, $signed(want), m_range_sum);
                        failed = 1'b1;
                    end
                end
            end
            if (!long_hold_done && accepted_words >= 120) begin
                long_hold_done = 1'b1;
                long_hold = 600;
            end
            if (long_hold > 0) begin
                long_hold--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) recv_gap = $urandom_range(1, 6);
            end
        end
    end

    // Random word, mostly well-formed ranges inside the count, with some noise.
    function automatic op_word_t random_word(input int unsigned cnt);
        op_word_t    w;
        int unsigned pick;
        int unsigned top;
        top = (cnt == 0) ? 1 : ((cnt > MAX_ELEMENTS) ? MAX_ELEMENTS : cnt);
        pick = $urandom_range(0, 99);
        if (pick < 35)      w.kind = KIND_LOAD;
        else if (pick < 65) w.kind = KIND_ADD;
        else if (pick < 97) w.kind = KIND_QUERY;
        else                w.kind = KIND_NONE;
        w.lo = POS_W'($urandom_range(1, top));
        w.hi = POS_W'($urandom_range(32'(w.lo), top));
        if ($urandom_range(0, 9) == 0) begin
            w.lo = POS_W'($urandom_range(0, 2047));
            w.hi = POS_W'($urandom_range(0, 2047));
        end
        case ($urandom_range(0, 3))
            0:       w.value = $urandom_range(0, 200) - 100;
            default: w.value = $urandom;
        endcase
        return w;
    endfunction

    task automatic wait_idle();
        while (pending_words.size() != 0 || s_valid || expected_sums.size() != 0)
            @(posedge aclk);
        // Loads and adds give no result, so let the last one finish inside the block.
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_count(input int unsigned cnt);
        @(posedge aclk);
        cfg_data  <= cnt[POS_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        elem_count = cnt;
        cfg_valid <= 1'b0;
    endtask

    int unsigned phase_counts [7] = '{1024, 1, 2047, 0, 5, 1025, 1024};
    int unsigned phase_words  [7] = '{120, 30, 120, 20, 60, 120, 180};

    initial begin
        for (int i = 1; i <= MAX_ELEMENTS; i++) elem_val[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset count: field extremes and every special case.
        pending_words.push_back('{KIND_QUERY, 11'd1, 11'd1024, 32'd0});    // all zero
        pending_words.push_back('{KIND_LOAD, 11'd1, 11'd0, 32'h7FFF_FFFF});
        pending_words.push_back('{KIND_LOAD, 11'd1024, 11'h7FF, 32'h8000_0000});
        pending_words.push_back('{KIND_LOAD, 11'd0, 11'd0, 32'd55});       // ignored load
        pending_words.push_back('{KIND_LOAD, 11'h7FF, 11'd5, 32'd77});     // ignored load
        pending_words.push_back('{KIND_ADD, 11'd0, 11'h7FF, 32'h8000_0000});
        pending_words.push_back('{KIND_QUERY, 11'd0, 11'h7FF, 32'hFFFF_FFFF});
        pending_words.push_back('{KIND_ADD, 11'd1, 11'd1024, 32'h7FFF_FFFF});
        pending_words.push_back('{KIND_QUERY, 11'd1, 11'd1, 32'd0});
        pending_words.push_back('{KIND_QUERY, 11'd1024, 11'd1024, 32'd0});
        pending_words.push_back('{KIND_QUERY, 11'd600, 11'd3, 32'd0});     // empty range
        pending_words.push_back('{KIND_ADD, 11'd9, 11'd2, 32'd100});       // empty add
        pending_words.push_back('{KIND_NONE, 11'd1, 11'd1024, 32'd9});     // unused kind
        pending_words.push_back('{KIND_LOAD, 11'd512, 11'd0, 32'hFFFF_FFFF});
        pending_words.push_back('{KIND_ADD, 11'd300, 11'd700, 32'h5555_AAAA});
        pending_words.push_back('{KIND_QUERY, 11'd256, 11'd768, 32'd0});
        pending_words.push_back('{KIND_QUERY, 11'd0, 11'd0, 32'd0});       // clips to empty
        pending_words.push_back('{KIND_QUERY, 11'd1, 11'd1024, 32'd0});

        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                wait_idle();
                write_count(phase_counts[p]);
            end
            if (p == 6) quiet = 1'b1;
            for (int n = 0; n < phase_words[p]; n++)
                pending_words.push_back(random_word(phase_counts[p]));
        end

        wait_idle();
        if (!failed) begin
            $display("range_add_range_sum_tree_core: match");
        end else begin
            $display("range_add_range_sum_tree_core: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("range_add_range_sum_tree_core: mismatch");
        $finish;
    end

endmodule

// ===== range_add_range_sum_tree_core.f =====
hw/rtl/rast_pkg.sv
hw/rtl/rast_mul.sv
hw/rtl/range_add_range_sum_tree_core.sv
hw/rtl/rast_checker.sv
tb/sv/range_add_range_sum_tree_core_tb.sv
